@@ design/contiguous_block_allocator_assert.svh @@
// Assertion macros used by the allocator controller.
`ifndef CONTIGUOUS_BLOCK_ALLOCATOR_ASSERT_SVH
`define CONTIGUOUS_BLOCK_ALLOCATOR_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define CBA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define CBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/cba_pkg.sv @@
`timescale 1ns / 1ps
package cba_pkg;
  localparam int unsigned NumBlocksDef  = 1024;
  localparam int unsigned BlockBytesDef = 8;
  localparam int unsigned OutBlkW       = 10;
  localparam int unsigned SizeW         = 13;

  localparam logic [1:0] OpAdd    = 2'd0;
  localparam logic [1:0] OpGet    = 2'd1;
  localparam logic [1:0] OpDelete = 2'd2;
  localparam logic [1:0] OpDefrag = 2'd3;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StNoSpace  = 2'd1;
  localparam logic [1:0] StNotFound = 2'd2;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // latch the incoming word
    logic clr_ptr;   // clear scan pointers
    logic step;      // advance the scan
    logic scan_rd;   // scan read issued this cycle (data next cycle)
    logic finish;    // compute result and update bump pointer
  } cba_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic rd_done;   // all reads issued
    logic wr_done;   // all writes of the current walk issued
    logic init_busy; // map clearing pass after reset still running
  } cba_sts_t;
endpackage

@@ design/cba_ram.sv @@
`timescale 1ns / 1ps
module cba_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ design/cba_datapath.sv @@
`timescale 1ns / 1ps
module cba_datapath import cba_pkg::*; #(
  parameter int unsigned NumBlocks  = NumBlocksDef,
  parameter int unsigned BlockBytes = BlockBytesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cba_cmd_t         cmd_i,
  output cba_sts_t         sts_o,
  input  logic [1:0]       op_i,
  input  logic [7:0]       id_i,
  input  logic [SizeW-1:0] size_i,
  output logic [1:0]       status_o,
  output logic [OutBlkW-1:0] start_o,
  output logic [OutBlkW-1:0] end_o
);
  localparam int unsigned AW = $clog2(NumBlocks);
  localparam int unsigned PW = AW + 1;
  localparam int unsigned CW = (SizeW > PW ? SizeW : PW) + 1;

  logic [1:0]       op_q;
  logic [7:0]       id_q;
  logic [CW-1:0]    cnt_q;
  logic [PW-1:0]    bump_q, bump_d;
  logic [PW-1:0]    rd_q;      // scan read index
  logic [PW-1:0]    wr_q;      // write index (add/clear walk or compaction)
  logic             vld_q;     // read data valid
  logic [PW-1:0]    vidx_q;    // index of the valid read data
  logic             seen_q;
  logic [PW-1:0]    first_q, last_q;
  logic             clearing_q; // defrag tail-clear phase
  logic [1:0]       status_q;
  logic [OutBlkW-1:0] start_q, end_q;
  logic             init_q;    // map clearing pass after reset
  logic [AW-1:0]    clr_q;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [7:0]       wdata, rdata;
  logic [CW-1:0]    room;
  logic             fits;
  logic             compact_end;

  assign room = CW'(NumBlocks) - CW'(bump_q);
  assign fits = cnt_q <= room;

  cba_ram #(.Width(8), .Depth(NumBlocks)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(rd_q[AW-1:0]),
    .rdata_o(rdata)
  );

  always_comb begin
    we    = 1'b0;
    waddr = wr_q[AW-1:0];
    wdata = 8'd0;
    case (op_q)
      OpAdd: begin
        we    = cmd_i.step && fits && (wr_q < PW'(cnt_q) + bump_q);
        wdata = id_q;
      end
      OpDelete: begin
        we    = vld_q && (id_q != 8'd0) && (rdata == id_q);
        waddr = vidx_q[AW-1:0];
      end
      OpDefrag: begin
        if (clearing_q) begin
          we = cmd_i.step && (wr_q < PW'(NumBlocks));
        end else begin
          we    = vld_q && (rdata != 8'd0);
          wdata = rdata;
        end
      end
      default: we = 1'b0;
    endcase
    if (init_q) begin
      we    = 1'b1;
      waddr = clr_q;
      wdata = 8'd0;
    end
  end

  always_comb begin
    sts_o.rd_done   = rd_q >= PW'(NumBlocks);
    sts_o.init_busy = init_q;
    case (op_q)
      OpAdd:    sts_o.wr_done = !fits || (wr_q >= PW'(cnt_q) + bump_q);
      OpDefrag: sts_o.wr_done = clearing_q && (wr_q >= PW'(NumBlocks));
      default:  sts_o.wr_done = 1'b1;
    endcase
  end

  // Compaction ends once the last read data is consumed.
  assign compact_end = (op_q == OpDefrag) && !cmd_i.clr_ptr && !clearing_q &&
                       sts_o.rd_done && !vld_q && !cmd_i.scan_rd;

  always_comb begin
    bump_d = bump_q;
    if (compact_end) bump_d = wr_q;
    if (cmd_i.finish && op_q == OpAdd && fits) bump_d = bump_q + PW'(cnt_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q       <= OpAdd;
      id_q       <= '0;
      cnt_q      <= '0;
      bump_q     <= '0;
      rd_q       <= '0;
      wr_q       <= '0;
      vld_q      <= 1'b0;
      vidx_q     <= '0;
      seen_q     <= 1'b0;
      first_q    <= '0;
      last_q     <= '0;
      clearing_q <= 1'b0;
      status_q   <= StOk;
      start_q    <= '0;
      end_q      <= '0;
      init_q     <= 1'b1;
      clr_q      <= '0;
    end else begin
      bump_q <= bump_d;
      vld_q  <= cmd_i.scan_rd;
      vidx_q <= rd_q;
      if (init_q) begin
        clr_q <= clr_q + AW'(1);
        if (clr_q == AW'(NumBlocks - 1)) init_q <= 1'b0;
      end
      if (cmd_i.load) begin
        op_q  <= op_i;
        id_q  <= id_i;
        cnt_q <= CW'(size_i / SizeW'(BlockBytes)) + CW'(1);
      end
      if (cmd_i.clr_ptr) begin
        rd_q       <= '0;
        wr_q       <= (op_q == OpAdd) ? bump_q : '0;
        seen_q     <= 1'b0;
        clearing_q <= 1'b0;
      end else begin
        if (cmd_i.scan_rd) rd_q <= rd_q + PW'(1);
        if (op_q == OpAdd && cmd_i.step) wr_q <= wr_q + PW'(1);
        if (op_q == OpDefrag) begin
          if (clearing_q) begin
            if (cmd_i.step) wr_q <= wr_q + PW'(1);
          end else if (vld_q && rdata != 8'd0) begin
            wr_q <= wr_q + PW'(1);
          end
          if (compact_end) clearing_q <= 1'b1;
        end
        if (op_q == OpGet && vld_q && id_q != 8'd0 && rdata == id_q) begin
          if (!seen_q) first_q <= vidx_q;
          last_q <= vidx_q;
          seen_q <= 1'b1;
        end
      end
      if (cmd_i.finish) begin
        status_q <= StOk;
        start_q  <= '0;
        end_q    <= '0;
        case (op_q)
          OpAdd: begin
            if (fits) begin
              start_q <= OutBlkW'(bump_q);
              end_q   <= OutBlkW'(bump_q + PW'(cnt_q) - PW'(1));
            end else begin
              status_q <= StNoSpace;
            end
          end
          OpGet: begin
            if (seen_q) begin
              start_q <= OutBlkW'(first_q);
              end_q   <= OutBlkW'(last_q);
            end else begin
              status_q <= StNotFound;
            end
          end
          default: status_q <= StOk;
        endcase
      end
    end
  end

  assign status_o = status_q;
  assign start_o  = start_q;
  assign end_o    = end_q;
endmodule

@@ design/cba_ctrl.sv @@
`timescale 1ns / 1ps
module cba_ctrl import cba_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_valid_i,
  output logic     s_ready_o,
  output logic     m_valid_o,
  input  logic     m_ready_i,
  input  logic [1:0] op_i,
  output cba_cmd_t cmd_o,
  input  cba_sts_t sts_i
);
  `include "contiguous_block_allocator_assert.svh"

  typedef enum logic [2:0] {
    StIdle, StStart, StScan, StDrain, StWalk, StDone, StOut
  } state_e;

  state_e state_q;
  logic   ready_q, valid_q;
  logic [1:0] op_q;
  logic   acc, take;

  assign acc  = s_valid_i && ready_q;
  assign take = valid_q && m_ready_i;

  always_comb begin
    cmd_o = '0;
    cmd_o.load    = acc;
    cmd_o.clr_ptr = state_q == StStart;
    cmd_o.scan_rd = state_q == StScan && !sts_i.rd_done && op_q != OpAdd;
    cmd_o.step    = state_q == StWalk;
    cmd_o.finish  = state_q == StDone;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ready_q <= 1'b0;
      valid_q <= 1'b0;
      op_q    <= OpAdd;
    end else begin
      case (state_q)
        StIdle: begin
          if (acc) begin
            ready_q <= 1'b0;
            op_q    <= op_i;
            state_q <= StStart;
          end else begin
            ready_q <= !sts_i.init_busy;
          end
        end
        StStart: state_q <= (op_q == OpAdd) ? StWalk : StScan;
        StScan:  if (sts_i.rd_done) state_q <= StDrain;
        StDrain: state_q <= (op_q == OpDefrag) ? StWalk : StDone;
        StWalk:  if (sts_i.wr_done) state_q <= StDone;
        StDone: begin
          valid_q <= 1'b1;
          state_q <= StOut;
        end
        StOut: begin
          if (take) begin
            valid_q <= 1'b0;
            ready_q <= 1'b1;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign s_ready_o = ready_q;
  assign m_valid_o = valid_q;

  `CBA_ASSERT_IMP(a_no_overlap, clk_i, rst_ni, valid_q, !ready_q, "accepting while result pending")
  `CBA_ASSERT_NEXT(a_acc_busy, clk_i, rst_ni, acc, !ready_q && state_q == StStart, "accept not taken")
  `CBA_ASSERT_IMP(a_valid_state, clk_i, rst_ni, valid_q, state_q == StOut, "result outside output state")
endmodule

@@ design/contiguous_block_allocator.sv @@
`timescale 1ns / 1ps
// From accept to result: add walks its blocks with one map write per cycle, an add
// without room writes nothing; get and delete make one map pass; defragment makes a
// read pass, then a tail clear.
// One word in flight at a time; the next can be accepted in the cycle after the result is delivered.
// Reset (rst_ni low, asynchronous) clears control and the bump pointer; then a clearing pass
// with s_axis_tready low writes every map entry free.
module contiguous_block_allocator import cba_pkg::*; #(
  parameter int unsigned NumBlocks  = NumBlocksDef,
  parameter int unsigned BlockBytes = BlockBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // operation[1:0], file_id[9:2], size_bytes[22:10]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // status[1:0], start_block[11:2], end_block[21:12]
);
  cba_cmd_t cmd;
  cba_sts_t sts;
  logic [1:0] status;
  logic [OutBlkW-1:0] sblk, eblk;

  cba_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid), .s_ready_o(s_axis_tready),
    .m_valid_o(m_axis_tvalid), .m_ready_i(m_axis_tready),
    .op_i(s_axis_tdata[1:0]), .cmd_o(cmd), .sts_i(sts)
  );

  cba_datapath #(.NumBlocks(NumBlocks), .BlockBytes(BlockBytes)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .op_i(s_axis_tdata[1:0]), .id_i(s_axis_tdata[9:2]),
    .size_i(s_axis_tdata[22:10]),
    .status_o(status), .start_o(sblk), .end_o(eblk)
  );

  assign m_axis_tdata = {2'b00, eblk, sblk, status};
endmodule
